// ===== design/icv_pkg.sv =====
// Package for the 7x7 image convolution block: field widths, command codes,
// beat payload types and the control bundle that drives the column cells.
// Depends on nothing; icv_line_buffer, icv_column_cell, image_convolution_7x7 and icv_checker import it.
package icv_pkg;

    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 5;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [PROD_W-1:0] t_prod;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd             command;
        logic [IDX_W-1:0] coef_index;
        t_pix             value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        t_pix             result;
        logic             frame_last;
    } t_out_item;

    typedef struct packed {
        logic             shift;
        logic             capture;
        logic             sum;
        logic             load;
        logic [IDX_W-1:0] coef_index;
        t_coef            coef;
    } t_cell_ctrl;

endpackage

// ===== design/icv_stream_if.sv =====
// Valid/ready stream channel with a typed payload, used for the pixel and
// result channels of the convolution block. No dependencies.
interface icv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/icv_line_buffer.sv =====
// Line store of the convolution block: one word per image column holding the
// buffered pixels of the rows above. Registered read. Depends on icv_pkg.
module icv_line_buffer
    import icv_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int LANES = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output t_pix [LANES-1:0]           o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  t_pix [LANES-1:0]           i_wr_data
);

    t_pix [LANES-1:0] r_mem [DEPTH];
    t_pix [LANES-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/icv_column_cell.sv =====
// One column cell of the window chain: holds a window column and the matching
// kernel column, forms the column products and their sum. Depends on icv_pkg.
module icv_column_cell
    import icv_pkg::*;
#(
    parameter int KERNEL_SIZE = 7,
    parameter int COL         = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_cell_ctrl                                i_ctrl,
    input  t_pix [KERNEL_SIZE-1:0]                    i_col,
    output t_pix [KERNEL_SIZE-1:0]                    o_col,
    output logic [PROD_W+$clog2(KERNEL_SIZE)-1:0]     o_sum
);

    localparam int SUM_W = PROD_W + $clog2(KERNEL_SIZE);

    t_pix  [KERNEL_SIZE-1:0] r_col;
    t_coef [KERNEL_SIZE-1:0] r_coef;
    t_prod [KERNEL_SIZE-1:0] r_prod;
    logic  [SUM_W-1:0]       r_sum;
    logic  [SUM_W-1:0]       n_sum;

    // Kernel column: cleared by reset, written by a load whose index lands here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_ctrl.load) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                if (i_ctrl.coef_index == IDX_W'(i * KERNEL_SIZE + COL)) begin
                    r_coef[i] <= i_ctrl.coef;
                end
            end
        end
    end

    // The incoming column is what this cell holds after the shift, so the
    // products are taken from it directly.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_col <= i_col;
        end
        if (i_ctrl.capture) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                r_prod[i] <= i_col[i] * r_coef[i];
            end
        end
        if (i_ctrl.sum) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            n_sum = n_sum + SUM_W'(r_prod[i]);
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

// ===== design/image_convolution_7x7.sv =====
// Top level of the streaming 7x7 image convolution: counters, line store,
// chain of column cells, final sum, rounding and output register.
// Depends on icv_pkg, icv_stream_if, icv_line_buffer and icv_column_cell.
//
//   Channel | Dir | Payload                                  | Beat means
//   --------+-----+------------------------------------------+---------------------------
//   i_in    | in  | command, coef_index, value               | one pixel or one coef load
//   o_out   | out | out_row, out_col, result, frame_last     | one interior result
//
// One input beat is taken per clock while no stalled result backs up to the
// input. A pixel beat that completes a window gives its result through the
// line store read, the product registers in the cells, the per-cell sums,
// the total and the output register. Every stage carries its own valid bit,
// so a stalled result only backs up the stages behind it and empty stages
// keep accepting. Synchronous active-low reset clears the counters, the
// valid bits and the kernel; the line store and the window hold no reset
// because nothing written before a full window has been seen reaches a result.
module image_convolution_7x7
    import icv_pkg::*;
#(
    parameter int IMAGE_SIZE  = 32,
    parameter int KERNEL_SIZE = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    icv_stream_if.sink    i_in,
    icv_stream_if.source  o_out
);

    localparam int CNT_W = $clog2(IMAGE_SIZE);
    localparam int LANES = KERNEL_SIZE - 1;
    localparam int OFF   = KERNEL_SIZE - 1 - KERNEL_SIZE / 2;
    localparam int SUM_W = PROD_W + $clog2(KERNEL_SIZE);
    localparam int TOT_W = SUM_W + $clog2(KERNEL_SIZE) + 1;

    localparam logic [CNT_W-1:0] LAST_POS   = CNT_W'(IMAGE_SIZE - 1);
    localparam logic [CNT_W-1:0] FIRST_FULL = CNT_W'(KERNEL_SIZE - 1);
    localparam logic [CNT_W-1:0] CENTER_OFF = CNT_W'(OFF);
    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (COEF_W - 1);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_tag;

    // Handshake and stage movement.
    t_in_item in_item;
    logic     in_ready;
    logic     in_fire;
    logic     in_pixel;
    logic     fire1;
    logic     rdy_p;
    logic     rdy_a;
    logic     rdy_b;
    logic     rdy_o;

    // Pixel position of the next pixel beat.
    logic [CNT_W-1:0] r_row_cnt;
    logic [CNT_W-1:0] r_col_cnt;
    logic [CNT_W+POS_W-1:0] crow_ext;
    logic [CNT_W+POS_W-1:0] ccol_ext;

    // First stage: the accepted beat while the line store read completes.
    logic             r_v1;
    t_cmd             r_cmd1;
    logic [IDX_W-1:0] r_idx1;
    t_pix             r_val1;
    logic [CNT_W-1:0] r_addr1;
    logic             r_res1;
    t_tag             r_tag1;

    // Later stages.
    logic             r_vp;
    t_tag             r_tag_p;
    logic             r_va;
    t_tag             r_tag_a;
    logic             r_vb;
    t_tag             r_tag_b;
    logic [TOT_W-1:0] r_tot;
    logic [TOT_W-1:0] n_tot;
    logic             r_vo;
    t_out_item        r_out;

    // Column data.
    t_pix [LANES-1:0]       lb_rd;
    t_pix [LANES-1:0]       lb_wr;
    t_pix [KERNEL_SIZE-1:0] new_col;
    t_pix [KERNEL_SIZE-1:0] cell_in  [KERNEL_SIZE];
    t_pix [KERNEL_SIZE-1:0] cell_col [KERNEL_SIZE];
    logic [SUM_W-1:0]       cell_sum [KERNEL_SIZE];
    t_cell_ctrl             cell_ctrl;

    assign in_item  = i_in.data;
    assign in_pixel = (in_item.command == CMD_PIXEL);

    // Ready runs back from the output register; a stage can take a beat when
    // it is empty or its own beat moves on in the same cycle.
    assign rdy_o    = !r_vo || o_out.ready;
    assign rdy_b    = !r_vb || rdy_o;
    assign rdy_a    = !r_va || rdy_b;
    assign rdy_p    = !r_vp || rdy_a;
    // Loads and border pixels finish in the first stage and never wait.
    assign fire1    = r_v1 && (!r_res1 || rdy_p);
    assign in_ready = !r_v1 || fire1;
    assign in_fire  = i_in.valid && in_ready;

    assign i_in.ready = in_ready;

    // Center position of the window that this pixel completes.
    assign crow_ext = {{POS_W{1'b0}}, r_row_cnt - CENTER_OFF};
    assign ccol_ext = {{POS_W{1'b0}}, r_col_cnt - CENTER_OFF};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_v1      <= 1'b0;
        end else begin
            if (in_ready) begin
                r_v1 <= i_in.valid;
            end
            if (in_fire && in_pixel) begin
                if (r_col_cnt == LAST_POS) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= (r_row_cnt == LAST_POS) ? '0 : r_row_cnt + CNT_W'(1);
                end else begin
                    r_col_cnt <= r_col_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd1      <= in_item.command;
            r_idx1      <= in_item.coef_index;
            r_val1      <= in_item.value;
            r_addr1     <= r_col_cnt;
            r_res1      <= in_pixel && (r_row_cnt >= FIRST_FULL) && (r_col_cnt >= FIRST_FULL);
            r_tag1.row  <= crow_ext[POS_W-1:0];
            r_tag1.col  <= ccol_ext[POS_W-1:0];
            r_tag1.last <= (r_row_cnt == LAST_POS) && (r_col_cnt == LAST_POS);
        end
    end

    // The new rightmost window column is the buffered rows above with the
    // fresh pixel at the bottom; the store keeps it shifted up by one row.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            new_col[i] = lb_rd[i];
        end
        new_col[KERNEL_SIZE-1] = r_val1;
        for (int i = 0; i < LANES; i++) begin
            lb_wr[i] = new_col[i+1];
        end
    end

    icv_line_buffer #(
        .DEPTH (IMAGE_SIZE),
        .LANES (LANES)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire && in_pixel),
        .i_rd_addr (r_col_cnt),
        .o_rd_data (lb_rd),
        .i_wr_en   (fire1 && (r_cmd1 == CMD_PIXEL)),
        .i_wr_addr (r_addr1),
        .i_wr_data (lb_wr)
    );

    // A coefficient load is applied at the same edge at which a pixel in its
    // place would take its products, which keeps loads and pixels in order.
    always_comb begin
        cell_ctrl.shift      = fire1 && (r_cmd1 == CMD_PIXEL);
        cell_ctrl.capture    = fire1 && r_res1;
        cell_ctrl.sum        = r_vp && rdy_a;
        cell_ctrl.load       = fire1 && (r_cmd1 == CMD_LOAD);
        cell_ctrl.coef_index = r_idx1;
        cell_ctrl.coef       = r_val1;
    end

    // Window columns move one cell to the left on every pixel beat.
    for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
        if (j == KERNEL_SIZE - 1) begin : g_edge
            assign cell_in[j] = new_col;
        end else begin : g_inner
            assign cell_in[j] = cell_col[j+1];
        end

        icv_column_cell #(
            .KERNEL_SIZE (KERNEL_SIZE),
            .COL         (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_col   (cell_in[j]),
            .o_col   (cell_col[j]),
            .o_sum   (cell_sum[j])
        );
    end

    // Total of the column sums with the rounding half added.
    always_comb begin
        n_tot = ROUND_HALF;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            n_tot = n_tot + TOT_W'(cell_sum[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_p) begin
                r_vp <= fire1 && r_res1;
            end
            if (rdy_a) begin
                r_va <= r_vp;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_o) begin
                r_vo <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1 && r_res1) begin
            r_tag_p <= r_tag1;
        end
        if (r_vp && rdy_a) begin
            r_tag_a <= r_tag_p;
        end
        if (r_va && rdy_b) begin
            r_tag_b <= r_tag_a;
            r_tot   <= n_tot;
        end
        if (r_vb && rdy_o) begin
            r_out.out_row    <= r_tag_b.row;
            r_out.out_col    <= r_tag_b.col;
            r_out.frame_last <= r_tag_b.last;
            // Scale back by the coefficient fraction and clip at full scale.
            if (|r_tot[TOT_W-1:PROD_W]) begin
                r_out.result <= '1;
            end else begin
                r_out.result <= r_tot[PROD_W-1:COEF_W];
            end
        end
    end

    assign o_out.valid = r_vo;
    assign o_out.data  = r_out;

endmodule

// ===== design/icv_checker.sv =====
// Port-level checks for the 7x7 image convolution block, attached to the top
// level by the bind statement at the end. Depends on icv_pkg.
module icv_checker
    import icv_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // A result beat that is not taken stays offered.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Its payload does not change while it waits.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // With the output register empty, every stage behind it can move, so an
    // offered input beat is taken.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_out_valid |-> i_in_ready)
        else $error("input blocked while the output register is empty");

    // The last result of a frame sits on the diagonal of the square image.
    a_last_on_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.frame_last |-> i_out_data.out_row == i_out_data.out_col)
        else $error("frame end flagged off the last interior pixel");

endmodule

bind image_convolution_7x7 icv_checker u_icv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for image_convolution_7x7: streams coefficient loads and
// pixels with bursty input and a stalling result sink, and checks every result beat.
// Depends on icv_pkg, icv_stream_if and the image_convolution_7x7 design.
module tb_top
    import icv_pkg::*;
();

    localparam int IMG          = 32;
    localparam int KSZ          = 7;
    localparam int KTAPS        = KSZ * KSZ;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 200;

    // Kernel shapes used when a whole kernel is reloaded.
    typedef enum int {
        KS_SPARSE = 0,
        KS_CENTER = 1,
        KS_SMALL  = 2,
        KS_FULL   = 3,
        KS_MAX    = 4
    } t_kernel_style;

    // Pixel value distributions for one segment of the stream.
    typedef enum int {
        PS_RANDOM = 0,
        PS_MAX    = 1,
        PS_ZERO   = 2,
        PS_LOW    = 3,
        PS_HIGH   = 4
    } t_pixel_style;

    // A queued input beat; hold_for_drain makes the sender wait until every
    // outstanding result has been received before offering it.
    typedef struct {
        t_in_item beat;
        bit       hold_for_drain;
    } t_queued_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    icv_stream_if #(.T(t_in_item))  in_if ();
    icv_stream_if #(.T(t_out_item)) out_if ();

    image_convolution_7x7 #(
        .IMAGE_SIZE  (IMG),
        .KERNEL_SIZE (KSZ)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_queued_beat queued_beats[$];
    t_out_item    expected_results[$];
    int           error_count = 0;
    int           cycle_count = 0;

    // Shadow copy of the block state, updated in acceptance order.
    t_coef kernel_coef [KTAPS];
    t_pix  line_store  [KSZ-1][IMG];
    t_pix  window_pix  [KSZ][KSZ];
    int    row_pos = 0;
    int    col_pos = 0;

    initial begin
        foreach (kernel_coef[k]) kernel_coef[k] = '0;
        foreach (line_store[i, j]) line_store[i][j] = '0;
        foreach (window_pix[i, j]) window_pix[i][j] = '0;
    end

    // Print is capped so a badly broken design cannot flood the log; every
    // mismatch is still counted.
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) $display("mismatch: %s", msg);
        error_count++;
    endtask

    // Applies one accepted beat to the shadow state and returns the result
    // beat that it causes, if any.
    function automatic void convolve_beat(input t_in_item b, output bit produced,
                                          output t_out_item res);
        t_pix            column [KSZ];
        longint unsigned acc;
        produced = 1'b0;
        res      = '0;
        if (b.command == CMD_LOAD) begin
            // Indexes past the last tap are dropped.
            if (b.coef_index < KTAPS) kernel_coef[b.coef_index] = b.value;
            return;
        end
        for (int i = 0; i < KSZ - 1; i++) column[i] = line_store[i][col_pos];
        column[KSZ-1] = b.value;
        for (int i = 0; i < KSZ; i++) begin
            for (int j = 0; j < KSZ - 1; j++) window_pix[i][j] = window_pix[i][j+1];
            window_pix[i][KSZ-1] = column[i];
        end
        for (int i = 0; i < KSZ - 1; i++) line_store[i][col_pos] = column[i+1];
        if (row_pos >= KSZ - 1 && col_pos >= KSZ - 1) begin
            acc = 0;
            for (int i = 0; i < KSZ; i++)
                for (int j = 0; j < KSZ; j++)
                    acc += 64'(window_pix[i][j]) * 64'(kernel_coef[i*KSZ+j]);
            // Round half up back to Q0.16, then clamp at full scale.
            acc = (acc + (64'd1 << (COEF_W - 1))) >> COEF_W;
            if (acc > 64'(t_pix'('1))) acc = 64'(t_pix'('1));
            res.out_row    = POS_W'(row_pos - (KSZ - 1) + KSZ / 2);
            res.out_col    = POS_W'(col_pos - (KSZ - 1) + KSZ / 2);
            res.result     = t_pix'(acc);
            res.frame_last = (row_pos == IMG - 1 && col_pos == IMG - 1);
            produced       = 1'b1;
        end
        if (col_pos + 1 >= IMG) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= IMG) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic t_coef pick_coef(input t_kernel_style style, input int tap);
        case (style)
            KS_SPARSE: return ($urandom_range(0, 4) == 0) ? t_coef'($urandom) : '0;
            KS_CENTER: return (tap == KTAPS / 2) ? t_coef'($urandom) : '0;
            KS_SMALL:  return t_coef'($urandom_range(0, 2047));
            KS_MAX:    return '1;
            default:   return t_coef'($urandom);
        endcase
    endfunction

    function automatic t_pix pick_pixel(input t_pixel_style style);
        case (style)
            PS_MAX:  return '1;
            PS_ZERO: return '0;
            PS_LOW:  return t_pix'($urandom_range(0, 255));
            PS_HIGH: return t_pix'($urandom_range(16'hF000, 16'hFFFF));
            default: return t_pix'($urandom);
        endcase
    endfunction

    task automatic queue_load(input int idx, input t_coef coef, input bit hold);
        t_queued_beat q;
        q.beat.command    = CMD_LOAD;
        q.beat.coef_index = IDX_W'(idx);
        q.beat.value      = coef;
        q.hold_for_drain  = hold;
        queued_beats.push_back(q);
    endtask

    task automatic queue_pixel(input t_pix pix, input int idx, input bit hold);
        t_queued_beat q;
        q.beat.command    = CMD_PIXEL;
        q.beat.coef_index = IDX_W'(idx);
        q.beat.value      = pix;
        q.hold_for_drain  = hold;
        queued_beats.push_back(q);
    endtask

    // Sender: bursts of random length separated by random gaps, some of them
    // empty so that back-to-back stretches occur as well.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0) begin
                in_if.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (queued_beats.size() != 0 &&
                         !(queued_beats[0].hold_for_drain &&
                           (in_if.valid || expected_results.size() != 0))) begin
                // A held beat waits until the channel has gone idle, so that the beat
                // just accepted has had its expectation recorded.
                in_if.valid <= 1'b1;
                in_if.data  <= queued_beats[0].beat;
                queued_beats.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, coin-flip stalls and a
    // rotating stall pattern.
    int          sink_mode = 0;
    int          mode_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready  <= 1'b0;
            sink_mode     <= 0;
            mode_left     <= 0;
            stall_pattern <= 16'hFFFF;
        end else begin
            if (mode_left == 0) begin
                sink_mode     <= $urandom_range(0, 2);
                mode_left     <= $urandom_range(16, 200);
                stall_pattern <= 16'($urandom) | 16'h0001;
            end else begin
                mode_left     <= mode_left - 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
            case (sink_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= 1'($urandom_range(0, 1));
                default: out_if.ready <= stall_pattern[0];
            endcase
        end
    end

    // Monitor: the result beat of this edge is checked before the input beat
    // of this edge is predicted, so the order is fixed within the edge.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        t_out_item predicted;
        bit        produced;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: row %0d col %0d",
                                              got.out_row, got.out_col));
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_row !== want.out_row)
                        report_mismatch($sformatf("out_row %0d, expected %0d",
                                                  got.out_row, want.out_row));
                    if (got.out_col !== want.out_col)
                        report_mismatch($sformatf("out_col %0d, expected %0d",
                                                  got.out_col, want.out_col));
                    if (got.result !== want.result)
                        report_mismatch($sformatf("result %h at (%0d,%0d), expected %h",
                                                  got.result, want.out_row, want.out_col,
                                                  want.result));
                    if (got.frame_last !== want.frame_last)
                        report_mismatch($sformatf("frame_last %b at (%0d,%0d), expected %b",
                                                  got.frame_last, want.out_row,
                                                  want.out_col, want.frame_last));
                end
            end
            if (in_if.valid && in_if.ready) begin
                convolve_beat(in_if.data, produced, predicted);
                if (produced) expected_results.push_back(predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_kernel_style kstyle;
        t_pixel_style  pstyle;
        int            random_items;
        int            seg_len;
        int            idx;
        bit            first_seg;
        bit            hold;

        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;

        // Directed beats: tap extremes, dropped indexes, pixel extremes and
        // pixels that carry a stray coefficient index.
        queue_load(0, 16'hFFFF, 1'b0);
        queue_load(KTAPS - 1, 16'hFFFF, 1'b0);
        queue_load(KTAPS / 2, 16'h8000, 1'b0);
        queue_load(KTAPS, 16'hABCD, 1'b0);
        queue_load(63, 16'hFFFF, 1'b0);
        queue_load(1, 16'h0000, 1'b0);
        queue_load(KTAPS - 2, 16'h0001, 1'b0);
        queue_load(2, 16'h5555, 1'b0);
        queue_load(3, 16'hAAAA, 1'b0);
        queue_pixel(16'h0000, 0, 1'b0);
        queue_pixel(16'hFFFF, 63, 1'b0);
        queue_pixel(16'h0001, 42, 1'b0);
        queue_pixel(16'h8000, 21, 1'b0);
        queue_pixel(16'h7FFF, 63, 1'b0);
        queue_pixel(16'hFFFF, 0, 1'b0);
        queue_pixel(16'h5555, 48, 1'b0);
        queue_pixel(16'hAAAA, 49, 1'b0);
        queue_pixel(16'h0000, 63, 1'b0);
        queue_pixel(16'hFFFF, 0, 1'b0);

        // Random segments: an optional whole-kernel reload, then a run of
        // pixels in one value style with occasional single-tap loads. Each
        // segment opens with a beat that waits for all results to drain.
        random_items = 0;
        first_seg    = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            hold = 1'b1;
            if (first_seg || $urandom_range(0, 2) == 0) begin
                kstyle = t_kernel_style'($urandom_range(0, 4));
                for (int k = 0; k < KTAPS; k++) begin
                    queue_load(k, pick_coef(kstyle, k), hold && (k == 0));
                end
                random_items += KTAPS;
                hold = 1'b0;
            end
            pstyle  = t_pixel_style'($urandom_range(0, 4));
            seg_len = $urandom_range(20, 300);
            if (seg_len > RANDOM_ITEMS - random_items) seg_len = RANDOM_ITEMS - random_items;
            for (int n = 0; n < seg_len; n++) begin
                if ($urandom_range(0, 24) == 0) begin
                    idx = $urandom_range(0, 63);
                    queue_load(idx, t_coef'($urandom), hold);
                end else begin
                    queue_pixel(pick_pixel(pstyle), $urandom_range(0, 63), hold);
                end
                random_items++;
                hold = 1'b0;
            end
            first_seg = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_beats.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/icv_pkg.sv
design/icv_stream_if.sv
design/icv_line_buffer.sv
design/icv_column_cell.sv
design/image_convolution_7x7.sv
design/icv_checker.sv
tb/tb_top.sv
